@@ sv/assert_macros.svh @@
// Assertion macros for the RTL files, included by the scheduler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ sv/tts_pkg.sv @@
// Types and constants of the tick task scheduler.
package tts_pkg;

  localparam int NUM_TASKS  = 16;
  localparam int IDX_W      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int PRIO_W     = 6;
  localparam int SLEEP_W    = 32;
  localparam int SLOT_IN_W  = 4;
  localparam int UPTIME_W   = 32;
  // One above the largest priority: no candidate found yet.
  localparam int BEST_W     = PRIO_W + 1;
  localparam logic [BEST_W-1:0] PRIO_NONE = BEST_W'(64);

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic               valid;
    logic [PRIO_W-1:0]  prio;
    logic               block;
    logic [SLEEP_W-1:0] sleep;
  } slot_wr_t;

  typedef struct packed {
    logic             step;
    logic [IDX_W-1:0] ptr;
  } scan_req_t;

  typedef struct packed {
    logic              ready;
    logic [PRIO_W-1:0] prio;
  } slot_info_t;

endpackage

@@ sv/tts_slot_table.sv @@
// Task slot table with the shared sleep decrement and readiness unit.
module tts_slot_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tts_pkg::slot_wr_t   wr_i,
  input  tts_pkg::scan_req_t  scan_i,
  output tts_pkg::slot_info_t info_o
);

  logic [tts_pkg::NUM_TASKS-1:0] valid_q;
  logic [tts_pkg::PRIO_W-1:0]    prio_q  [tts_pkg::NUM_TASKS];
  logic                          block_q [tts_pkg::NUM_TASKS];
  logic [tts_pkg::SLEEP_W-1:0]   sleep_q [tts_pkg::NUM_TASKS];

  logic                        cur_valid;
  logic [tts_pkg::SLEEP_W-1:0] cur_sleep;
  logic [tts_pkg::SLEEP_W-1:0] sleep_dec;

  assign cur_valid = valid_q[scan_i.ptr];
  assign cur_sleep = sleep_q[scan_i.ptr];
  // The countdown saturates at zero.
  assign sleep_dec = (cur_sleep != '0) ? (cur_sleep - 1'b1) : cur_sleep;

  assign info_o.ready = cur_valid && !block_q[scan_i.ptr] && (sleep_dec == '0);
  assign info_o.prio  = prio_q[scan_i.ptr];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx] <= wr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      prio_q[wr_i.idx]  <= wr_i.prio;
      block_q[wr_i.idx] <= wr_i.block;
      sleep_q[wr_i.idx] <= wr_i.sleep;
    end else if (scan_i.step && cur_valid) begin
      sleep_q[scan_i.ptr] <= sleep_dec;
    end
  end

endmodule

@@ sv/tick_task_scheduler.sv @@
// Top level of the tick task scheduler.
// A write item is answered in the cycle after it is accepted; a tick item after a scan of
// all NUM_TASKS slots, one slot per cycle through the shared decrement and compare unit.
// Throughput: one write item per cycle unless the output stalls; none is taken in a scan.
// Reset clears the slot valid bits, the current task and the uptime; no clearing pass.
// The slot priority, blocked flag and sleep fields hold no reset value.
`include "assert_macros.svh"

module tick_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // slot_index[3:0], slot_valid[4], slot_priority[10:5], slot_blocked[11],
  // slot_sleep[43:12], zero[47:44]
  input  logic [47:0] s_axis_tdata_i,
  // command[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // running_task[3:0], uptime[35:4], zero[39:36]
  output logic [39:0] m_axis_tdata_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;

  logic [1:0] state_q, state_d;
  logic [tts_pkg::IDX_W-1:0]    cur_q, cur_d;
  logic [tts_pkg::IDX_W-1:0]    ptr_q, ptr_d;
  logic [tts_pkg::IDX_W-1:0]    cnt_q, cnt_d;
  logic [tts_pkg::IDX_W-1:0]    chosen_q, chosen_d;
  logic [tts_pkg::BEST_W-1:0]   best_q, best_d;
  logic [tts_pkg::UPTIME_W-1:0] tick_q, tick_d;
  logic                         out_valid_q, out_valid_d;
  logic [39:0]                  out_data_q, out_data_d;

  logic                       in_acc;
  logic                       out_acc;
  logic                       idx_ok;
  logic [tts_pkg::IDX_W-1:0]  ptr_next;
  logic [tts_pkg::IDX_W-1:0]  cur_next;
  logic                       last_step;
  tts_pkg::slot_wr_t          wr;
  tts_pkg::scan_req_t         scan;
  tts_pkg::slot_info_t        info;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = out_valid_q && m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign idx_ok = 32'(s_axis_tdata_i[3:0]) < 32'(tts_pkg::NUM_TASKS);

  assign wr.en    = in_acc && (s_axis_tuser_i == tts_pkg::CMD_WRITE) && idx_ok;
  assign wr.idx   = tts_pkg::IDX_W'(s_axis_tdata_i[3:0]);
  assign wr.valid = s_axis_tdata_i[4];
  assign wr.prio  = s_axis_tdata_i[10:5];
  assign wr.block = s_axis_tdata_i[11];
  assign wr.sleep = s_axis_tdata_i[43:12];

  assign scan.step = (state_q == ST_SCAN);
  assign scan.ptr  = ptr_q;

  assign ptr_next  = (ptr_q == tts_pkg::IDX_W'(tts_pkg::NUM_TASKS - 1)) ? '0 : ptr_q + 1'b1;
  assign cur_next  = (cur_q == tts_pkg::IDX_W'(tts_pkg::NUM_TASKS - 1)) ? '0 : cur_q + 1'b1;
  assign last_step = (cnt_q == tts_pkg::IDX_W'(tts_pkg::NUM_TASKS - 1));

  tts_slot_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .scan_i (scan),
    .info_o (info)
  );

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    chosen_d    = chosen_q;
    best_d      = best_q;
    tick_d      = tick_q;
    out_valid_d = out_valid_q && !out_acc;
    out_data_d  = out_data_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == tts_pkg::CMD_TICK) begin
            tick_d   = tick_q + 1'b1;
            ptr_d    = cur_next;
            cnt_d    = '0;
            chosen_d = cur_q;
            best_d   = tts_pkg::PRIO_NONE;
            state_d  = ST_SCAN;
          end else begin
            out_valid_d = 1'b1;
            out_data_d  = {4'b0, tick_q, 4'(cur_q)};
          end
        end
      end
      ST_SCAN: begin
        // Strict compare keeps the earlier slot in ring order on a tie.
        if (info.ready && ({1'b0, info.prio} < best_q)) begin
          best_d   = {1'b0, info.prio};
          chosen_d = ptr_q;
        end
        ptr_d = ptr_next;
        cnt_d = cnt_q + 1'b1;
        if (last_step) begin
          // The output register was drained when this tick was accepted.
          cur_d       = chosen_d;
          out_valid_d = 1'b1;
          out_data_d  = {4'b0, tick_q, 4'(chosen_d)};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    cnt_q      <= cnt_d;
    chosen_q   <= chosen_d;
    best_q     <= best_d;
    out_data_q <= out_data_d;
  end

  `ASSERT_IMP(a_no_result_in_scan, state_q == ST_SCAN, !out_valid_q)
  `ASSERT_NEXT(a_tick_counts, in_acc && (s_axis_tuser_i == tts_pkg::CMD_TICK), tick_q == $past(tick_q) + 1'b1)
  `ASSERT_NEXT(a_write_answers, in_acc && (s_axis_tuser_i == tts_pkg::CMD_WRITE), out_valid_q && (out_data_q[3:0] == 4'($past(cur_q))))
  `ASSERT_NEXT(a_cur_holds_in_scan, (state_q == ST_SCAN) && !last_step, $stable(cur_q))

endmodule
